### hdl/dbc_pkg.sv
// Package for the data-dependent rotation block cipher.
// Holds the shared widths, reset values and item kind codes; depends on nothing.
package dbc_pkg;

  localparam int MAX_ROUNDS_DEFAULT = 32;

  localparam int WORD_W      = 32;
  localparam int ROUNDS_W    = 6;
  localparam int KIND_W      = 2;
  localparam int KEY_INDEX_W = 9;
  localparam int ROT_W       = 5;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 6'd20;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCRYPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DECRYPT = 2'd2;

endpackage

### hdl/dbc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the round-key table of the cipher.
module dbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 258
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/ddr_block_cipher_8x32.sv
// Top level of the 256-bit block cipher with data-dependent rotations; uses dbc_pkg and
// dbc_ram. A load transaction (kind 0) writes one round key into a table of
// 8*MAX_ROUNDS+2 words; indexes beyond the table are dropped, and kind 3 is taken
// and ignored. An encrypt (kind 1) or decrypt (kind 2) transaction runs one word
// operation per cycle through a single rotate/add unit: 8*rounds+2 operations for
// the whitening additions and the word steps, with the round key for each operation
// read from the key RAM in the cycle before. in_ready is low from acceptance until the
// result is taken, so no new transaction is accepted meanwhile. The rounds register
// must be written through the cfg channel only while the block is idle; the block
// itself does not enforce this. Values above MAX_ROUNDS are used as MAX_ROUNDS.
// Keys must be loaded before a block reads them.
module ddr_block_cipher_8x32 #(
  parameter int MAX_ROUNDS = dbc_pkg::MAX_ROUNDS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dbc_pkg::ROUNDS_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dbc_pkg::KIND_W-1:0]      kind,
  input  logic [dbc_pkg::KEY_INDEX_W-1:0] key_index,
  input  logic [dbc_pkg::WORD_W-1:0]      key_value,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word0,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word1,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word2,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word3,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word4,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word5,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word6,
  input  logic [dbc_pkg::WORD_W-1:0]      in_word7,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dbc_pkg::WORD_W-1:0]      out_word0,
  output logic [dbc_pkg::WORD_W-1:0]      out_word1,
  output logic [dbc_pkg::WORD_W-1:0]      out_word2,
  output logic [dbc_pkg::WORD_W-1:0]      out_word3,
  output logic [dbc_pkg::WORD_W-1:0]      out_word4,
  output logic [dbc_pkg::WORD_W-1:0]      out_word5,
  output logic [dbc_pkg::WORD_W-1:0]      out_word6,
  output logic [dbc_pkg::WORD_W-1:0]      out_word7
);

  localparam int KEY_DEPTH = 8 * MAX_ROUNDS + 2;
  localparam int IW        = $clog2(KEY_DEPTH);
  localparam int RW        = $clog2(MAX_ROUNDS + 1);
  localparam int RCW       = (RW > dbc_pkg::ROUNDS_W) ? RW : dbc_pkg::ROUNDS_W;
  localparam int KW        = (IW + 1 > dbc_pkg::KEY_INDEX_W) ? IW + 1 : dbc_pkg::KEY_INDEX_W;
  localparam int WW        = dbc_pkg::WORD_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                       state;
  logic [dbc_pkg::ROUNDS_W-1:0] rounds;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                last_plus1;
  logic                         encrypt;
  logic [7:0][WW-1:0]           words;

  logic [RW-1:0]      eff_rounds;
  logic [IW-1:0]      last_plus1_next;
  logic               in_accept;
  logic               block_item;
  logic               key_in_range;
  logic               ram_we;
  logic [IW-1:0]      ram_rd_addr;
  logic [WW-1:0]      round_key;
  logic               idx_zero;
  logic               idx_top;
  logic               step;
  logic               run_final;
  logic [WW-1:0]      a_word;
  logic [WW-1:0]      b_mask;
  logic [dbc_pkg::ROT_W-1:0] rot_amt;
  logic [WW-1:0]      rot_in;
  logic [WW-1:0]      rot_out;
  logic [WW-1:0]      res;
  logic [7:0][WW-1:0] words_w;
  logic [7:0][WW-1:0] words_next;

  function automatic logic [WW-1:0] rotl(input logic [WW-1:0] x,
                                         input logic [dbc_pkg::ROT_W-1:0] n);
    logic [2*WW-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WW-1:WW];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign in_accept = in_valid && in_ready;

  assign block_item   = kind inside {dbc_pkg::KIND_ENCRYPT, dbc_pkg::KIND_DECRYPT};
  assign key_in_range = KW'(key_index) < KW'(KEY_DEPTH);
  assign ram_we       = in_accept && (kind == dbc_pkg::KIND_LOAD) && key_in_range;

  assign eff_rounds = (RCW'(rounds) > RCW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(rounds);
  assign last_plus1_next = IW'({eff_rounds, 3'b001});

  // The key for the operation done in a cycle is addressed in the cycle before.
  always_comb begin
    case (state)
      ST_IDLE: ram_rd_addr = (kind == dbc_pkg::KIND_ENCRYPT) ? '0 : last_plus1_next;
      ST_RUN:  ram_rd_addr = encrypt ? idx + IW'(1) : idx - IW'(1);
      default: ram_rd_addr = idx;
    endcase
  end

  dbc_ram #(
    .WIDTH (WW),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (IW'(key_index)),
    .wr_data (key_value),
    .rd_en   (1'b1),
    .rd_addr (ram_rd_addr),
    .rd_data (round_key)
  );

  // The word register is kept rotated so that the word being changed by a step sits
  // in position 0 and its neighbour in position 1. On loading, position k holds block
  // word k+1, and both directions finish in that same alignment.
  assign idx_zero  = (idx == '0);
  assign idx_top   = (idx == last_plus1);
  assign step      = !(idx_zero || idx_top);
  assign run_final = encrypt ? idx_top : idx_zero;

  always_comb begin
    if (idx_zero) begin
      a_word = encrypt ? words[1] : words[2];
    end else begin
      a_word = words[0];
    end
    b_mask  = step ? words[1] : '0;
    rot_amt = '0;
    if (step) begin
      rot_amt = encrypt ? words[1][dbc_pkg::ROT_W-1:0]
                        : dbc_pkg::ROT_W'(0) - words[1][dbc_pkg::ROT_W-1:0];
    end
    rot_in  = encrypt ? (a_word ^ b_mask) : (a_word - round_key);
    rot_out = rotl(rot_in, rot_amt);
    res     = encrypt ? (rot_out + round_key) : (rot_out ^ b_mask);

    words_w = words;
    if (idx_zero) begin
      if (encrypt) begin
        words_w[1] = res;
      end else begin
        words_w[2] = res;
      end
    end else begin
      words_w[0] = res;
    end

    words_next = words_w;
    if ((encrypt && step) || (!encrypt && idx_zero)) begin
      for (int k = 0; k < 8; k++) begin
        words_next[k] = words_w[3'(k + 1)];
      end
    end else if (!encrypt) begin
      for (int k = 0; k < 8; k++) begin
        words_next[k] = words_w[3'(k + 7)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rounds <= dbc_pkg::ROUNDS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rounds <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && block_item) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (run_final) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (in_accept && block_item) begin
        encrypt    <= (kind == dbc_pkg::KIND_ENCRYPT);
        last_plus1 <= last_plus1_next;
        idx        <= (kind == dbc_pkg::KIND_ENCRYPT) ? '0 : last_plus1_next;
        words      <= {in_word0, in_word7, in_word6, in_word5,
                       in_word4, in_word3, in_word2, in_word1};
      end
    end else if (state == ST_RUN) begin
      words <= words_next;
      if (!run_final) begin
        idx <= encrypt ? idx + IW'(1) : idx - IW'(1);
      end
    end
  end

  assign out_word0 = words[7];
  assign out_word1 = words[0];
  assign out_word2 = words[1];
  assign out_word3 = words[2];
  assign out_word4 = words[3];
  assign out_word5 = words[4];
  assign out_word6 = words[5];
  assign out_word7 = words[6];

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (idx <= last_plus1))
    else $error("Key index ran past the last key of the block.");

  a_block_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && block_item) |=> (state == ST_RUN))
    else $error("Accepted block transaction did not start the word steps.");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && run_final) |=> out_valid)
    else $error("Final word operation did not present a result.");

  a_limit_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && $past(state == ST_RUN)) |-> $stable(last_plus1))
    else $error("Key range changed while a block was in progress.");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("Key table written while a block was in progress.");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for ddr_block_cipher_8x32, the 256-bit rotation block cipher.
// Holds its own cipher predictor in a scoreboard class; depends on dbc_pkg and the RTL.
// Loads keys, encrypts and decrypts blocks under several round settings and idle patterns.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_R       = 32;
  localparam int KEY_DEPTH   = 8 * MAX_R + 2;
  localparam int LIMIT       = 1_000_000;
  localparam int SETTLE      = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 68;
  localparam int PRESSURE_PHASE = 4;

  localparam logic [dbc_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

  typedef logic [dbc_pkg::WORD_W-1:0] word_t;
  typedef logic [7:0][dbc_pkg::WORD_W-1:0] block_t;

  typedef struct packed {
    logic [dbc_pkg::KIND_W-1:0]      kind;
    logic [dbc_pkg::KEY_INDEX_W-1:0] key_index;
    word_t                           key_value;
    block_t                          words;
  } item_t;

  class cipher_scoreboard;
    word_t                        round_key [KEY_DEPTH];
    logic [dbc_pkg::ROUNDS_W-1:0] rounds;
    block_t                       pending [$];
    int                           errors;

    function new();
      rounds = dbc_pkg::ROUNDS_RESET;
      errors = 0;
      foreach (round_key[i]) round_key[i] = '0;
    endfunction

    function void set_rounds(logic [dbc_pkg::ROUNDS_W-1:0] r);
      rounds = r;
    endfunction

    function word_t rotl(word_t x, logic [4:0] n);
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function word_t rotr(word_t x, logic [4:0] n);
      if (n == 0) return x;
      return (x >> n) | (x << (32 - n));
    endfunction

    function int step_count();
      return 8 * ((rounds > MAX_R) ? MAX_R : rounds);
    endfunction

    function block_t encipher(block_t w);
      int    last;
      word_t nb;
      last = step_count();
      w[2] = w[2] + round_key[0];
      for (int i = 1; i <= last; i++) begin
        nb = w[(i + 1) % 8];
        w[i % 8] = rotl(w[i % 8] ^ nb, nb[4:0]) + round_key[i];
      end
      w[1] = w[1] + round_key[last + 1];
      return w;
    endfunction

    // Steps run backwards; the neighbour word is already restored when a word is undone.
    function block_t decipher(block_t w);
      int    last;
      word_t nb;
      last = step_count();
      w[1] = w[1] - round_key[last + 1];
      for (int i = last; i > 0; i--) begin
        nb = w[(i + 1) % 8];
        w[i % 8] = rotr(w[i % 8] - round_key[i], nb[4:0]) ^ nb;
      end
      w[2] = w[2] - round_key[0];
      return w;
    endfunction

    function bit note_input(item_t it, output block_t res);
      res = it.words;
      case (it.kind)
        dbc_pkg::KIND_LOAD: begin
          if (it.key_index < KEY_DEPTH) round_key[it.key_index] = it.key_value;
          return 1'b0;
        end
        dbc_pkg::KIND_ENCRYPT: res = encipher(it.words);
        dbc_pkg::KIND_DECRYPT: res = decipher(it.words);
        default: return 1'b0;
      endcase
      pending.push_back(res);
      return 1'b1;
    endfunction

    function void check_result(block_t got);
      block_t want;
      if (pending.size() == 0) begin
        $error("result with no block transaction waiting for it: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int j = 0; j < 8; j++) begin
        if (got[j] !== want[j]) begin
          $error("out_word%0d: expected %h, got %h", j, want[j], got[j]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dbc_pkg::ROUNDS_W-1:0]    cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [dbc_pkg::KIND_W-1:0]      kind;
  logic [dbc_pkg::KEY_INDEX_W-1:0] key_index;
  word_t                           key_value;
  word_t                           in_word0, in_word1, in_word2, in_word3;
  word_t                           in_word4, in_word5, in_word6, in_word7;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  word_t                           out_word0, out_word1, out_word2, out_word3;
  word_t                           out_word4, out_word5, out_word6, out_word7;

  cipher_scoreboard             sb;
  bit                           key_loaded [KEY_DEPTH];
  logic [dbc_pkg::ROUNDS_W-1:0] cur_rounds = dbc_pkg::ROUNDS_RESET;
  block_t                       last_cipher;
  bit                           have_cipher = 1'b0;
  int                           send_idle_pct = 0;
  int                           stall_pct = 0;
  logic                         hold_req = 1'b0;
  int                           hold_left = 0;
  bit                           hold_done = 1'b0;
  int                           cycle_count = 0;

  int phase_rounds [PHASES] = '{20, 0, 63, 32, 2, 9, 1, 5};
  int phase_send   [PHASES] = '{0, 78, 0, 28, 0, 78, 0, 28};
  int phase_recv   [PHASES] = '{0, 0, 78, 28, 0, 0, 78, 28};

  ddr_block_cipher_8x32 #(.MAX_ROUNDS(MAX_R)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .key_index (key_index),
    .key_value (key_value),
    .in_word0  (in_word0),
    .in_word1  (in_word1),
    .in_word2  (in_word2),
    .in_word3  (in_word3),
    .in_word4  (in_word4),
    .in_word5  (in_word5),
    .in_word6  (in_word6),
    .in_word7  (in_word7),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word0 (out_word0),
    .out_word1 (out_word1),
    .out_word2 (out_word2),
    .out_word3 (out_word3),
    .out_word4 (out_word4),
    .out_word5 (out_word5),
    .out_word6 (out_word6),
    .out_word7 (out_word7)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: checks each transaction and decides out_ready for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result({out_word7, out_word6, out_word5, out_word4,
                         out_word3, out_word2, out_word1, out_word0});
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic block_t rand_block();
    block_t b;
    for (int j = 0; j < 8; j++) b[j] = rand_word();
    return b;
  endfunction

  task automatic send_item(input item_t it);
    block_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= it.kind;
    key_index <= it.key_index;
    key_value <= it.key_value;
    {in_word7, in_word6, in_word5, in_word4,
     in_word3, in_word2, in_word1, in_word0} <= it.words;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_input(it, res) && it.kind == dbc_pkg::KIND_ENCRYPT) begin
      last_cipher = res;
      have_cipher = 1'b1;
    end
    if (it.kind == dbc_pkg::KIND_LOAD && it.key_index < KEY_DEPTH) begin
      key_loaded[it.key_index] = 1'b1;
    end
  endtask

  task automatic load_key(input int idx, input word_t value);
    item_t it;
    it.kind      = dbc_pkg::KIND_LOAD;
    it.key_index = dbc_pkg::KEY_INDEX_W'(idx);
    it.key_value = value;
    it.words     = rand_block();
    send_item(it);
  endtask

  task automatic send_block(input logic [dbc_pkg::KIND_W-1:0] k, input block_t b);
    item_t it;
    it.kind      = k;
    it.key_index = dbc_pkg::KEY_INDEX_W'($urandom);
    it.key_value = $urandom;
    it.words     = b;
    send_item(it);
  endtask

  task automatic write_rounds(input logic [dbc_pkg::ROUNDS_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_rounds(r);
    cur_rounds = r;
  endtask

  // Loads and ignored kinds give no result, so settle for a full block time as well.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    item_t it;
    int    r;
    int    needed;
    sb = new();
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = dbc_pkg::KIND_LOAD;
    key_index = '0;
    key_value = '0;
    {in_word7, in_word6, in_word5, in_word4, in_word3, in_word2, in_word1, in_word0} = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with a single round, so only keys 0 to 9 are read.
    write_rounds(6'd1);
    for (int i = 0; i < 10; i++) begin
      load_key(i, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF :
               (i == 2) ? 32'h8000_0000 : $urandom);
    end
    load_key(KEY_DEPTH - 1, $urandom);
    load_key(KEY_DEPTH, '1);
    load_key(511, '1);
    it.kind      = KIND_NONE;
    it.key_index = dbc_pkg::KEY_INDEX_W'($urandom);
    it.key_value = $urandom;
    it.words     = rand_block();
    send_item(it);
    send_block(dbc_pkg::KIND_ENCRYPT, '0);
    send_block(dbc_pkg::KIND_ENCRYPT, '1);
    send_block(dbc_pkg::KIND_DECRYPT, '0);
    send_block(dbc_pkg::KIND_ENCRYPT, rand_block());
    send_block(dbc_pkg::KIND_DECRYPT, last_cipher);
    // Neighbour words whose low five bits are zero give rotations by nothing.
    send_block(dbc_pkg::KIND_ENCRYPT, {8{32'h8000_0020}});
    send_block(dbc_pkg::KIND_DECRYPT, {8{32'hABCD_EF00}});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      send_idle_pct = phase_send[p];
      stall_pct     = phase_recv[p];
      write_rounds(dbc_pkg::ROUNDS_W'(phase_rounds[p]));
      if (p == PRESSURE_PHASE) hold_req <= 1'b1;
      needed = 8 * ((cur_rounds > MAX_R) ? MAX_R : cur_rounds) + 2;
      for (int i = 0; i < needed; i++) begin
        if (!key_loaded[i]) load_key(i, rand_word());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.kind      = dbc_pkg::KIND_LOAD;
        it.key_index = dbc_pkg::KEY_INDEX_W'($urandom_range(0, KEY_DEPTH - 1));
        it.key_value = rand_word();
        it.words     = rand_block();
        r = $urandom_range(99);
        if (r < 4) begin
          it.kind = KIND_NONE;
        end else if (r < 8) begin
          it.key_index = dbc_pkg::KEY_INDEX_W'($urandom_range(KEY_DEPTH, 511));
        end else if (r >= 22 && r < 60) begin
          it.kind = dbc_pkg::KIND_ENCRYPT;
        end else if (r >= 60) begin
          it.kind = dbc_pkg::KIND_DECRYPT;
          if (have_cipher && r < 80) it.words = last_cipher;
        end
        send_item(it);
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
